[rtl/fdp_pkg.sv]
`default_nettype none

package fdp_pkg;

  localparam int BYTE_W        = 8;
  localparam int ANGLE_W       = 40;
  localparam int HDR_W         = 4;
  localparam int APB_ADDR_W    = 3;
  localparam int APB_DATA_W    = 32;
  localparam int PAYLOAD_MAX   = 8;

  localparam int FRAME_LENGTH_DEF = 15;
  localparam int FRAC_DIGITS_DEF  = 4;

  localparam logic [HDR_W-1:0]   HEADER_LENGTH_RESET = 4'd6;
  localparam logic [ANGLE_W-1:0] VALUE_MAX = 40'hFF_FFFF_FFFF;

  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_POINT = 8'h2E;
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

  // register index taken from paddr[2]
  localparam logic REG_HEADER_LENGTH = 1'b0;

  typedef struct packed {
    logic [ANGLE_W-1:0] angle_value;
    logic               malformed;
  } fdp_result_t;

  function automatic longint unsigned pow10(input int n);
    longint unsigned p;
    p = 64'd1;
    for (int i = 0; i < n; i++) begin
      p = p * 64'd10;
    end
    return p;
  endfunction

endpackage

`default_nettype wire

[rtl/framed_ascii_decimal_parser.sv]
`default_nettype none

// Channel   Direction  Handshake          Word
// input     in         in_valid/in_stall  rx_byte
// output    out        out_valid/out_stall angle_value, malformed
// config    in         APB write/read     header_length at address 0
//
// One byte per cycle sustained unless a stalled result holds a CR; a byte
// is folded into the frame state at the edge it leaves the input register.
// A result enters the output register at the edge its carriage return
// leaves the input register. While a result waits stalled, other bytes keep
// flowing; only a carriage return inside a frame is held back. Reset is
// synchronous; it resets control, frame and config state, not data registers.

module framed_ascii_decimal_parser import fdp_pkg::*; #(
  parameter int FRAME_LENGTH = FRAME_LENGTH_DEF,
  parameter int FRAC_DIGITS  = FRAC_DIGITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [BYTE_W-1:0]     rx_byte,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [ANGLE_W-1:0]         angle_value,
  output logic                       malformed,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0]      prdata,
  output logic                       pready
);

  logic              hold_valid;
  logic [BYTE_W-1:0] hold_byte;
  logic [HDR_W-1:0]  header_length;
  logic              emits;
  logic              blocked;
  logic              advance;
  fdp_result_t       result;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_length <= HEADER_LENGTH_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_HEADER_LENGTH) begin
      header_length <= pwdata[HDR_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_HEADER_LENGTH) begin
      prdata = APB_DATA_W'(header_length);
    end
  end

  assign blocked  = out_valid && out_stall;
  assign advance  = hold_valid && (!emits || !blocked);
  assign in_stall = hold_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!in_stall) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      hold_byte <= rx_byte;
    end
  end

  fdp_core #(
    .FRAME_LENGTH (FRAME_LENGTH),
    .FRAC_DIGITS  (FRAC_DIGITS)
  ) u_core (
    .clk           (clk),
    .rst           (rst),
    .step          (advance),
    .rx_byte       (hold_byte),
    .header_length (header_length),
    .emits         (emits),
    .result        (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && emits) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emits) begin
      angle_value <= result.angle_value;
      malformed   <= result.malformed;
    end
  end

endmodule

`default_nettype wire

[rtl/fdp_core.sv]
`default_nettype none

module fdp_core import fdp_pkg::*; #(
  parameter int FRAME_LENGTH = FRAME_LENGTH_DEF,
  parameter int FRAC_DIGITS  = FRAC_DIGITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              step,
  input  wire logic [BYTE_W-1:0] rx_byte,
  input  wire logic [HDR_W-1:0]  header_length,
  output logic                   emits,
  output fdp_result_t            result
);

  localparam int P_W   = $clog2(FRAME_LENGTH);
  localparam int VAL_W = $clog2(pow10(PAYLOAD_MAX + FRAC_DIGITS));
  localparam int CNT_W = $clog2(FRAC_DIGITS + 1);
  localparam int CMP_W = (VAL_W > ANGLE_W) ? VAL_W : ANGLE_W;

  // weight of an integer digit in the fixed-point value
  localparam logic [VAL_W-1:0] INT_SCALE = VAL_W'(pow10(FRAC_DIGITS));

  logic             in_frame,       in_frame_next;
  logic [P_W-1:0]   frame_position, frame_position_next;
  logic [VAL_W-1:0] value,          value_next;
  logic [CNT_W-1:0] frac_count,     frac_count_next;
  logic             point_seen,     point_seen_next;
  logic             error_seen,     error_seen_next;

  logic [VAL_W-1:0] frac_scale [FRAC_DIGITS];
  logic [VAL_W-1:0] scale;
  logic [3:0]       digit;
  logic             is_digit;
  logic [P_W:0]     pos_ext;
  logic [P_W:0]     hdr_ext;

  // weight of the next fractional digit
  for (genvar g = 0; g < FRAC_DIGITS; g++) begin : g_scale
    assign frac_scale[g] = VAL_W'(pow10(FRAC_DIGITS - 1 - g));
  end

  always_comb begin
    scale = '0;
    for (int i = 0; i < FRAC_DIGITS; i++) begin
      if (frac_count == CNT_W'(i)) begin
        scale = frac_scale[i];
      end
    end
  end

  assign digit    = rx_byte[3:0];
  assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
  assign pos_ext  = {1'b0, frame_position};
  assign hdr_ext  = (P_W+1)'(header_length);
  assign emits    = in_frame && (rx_byte == CH_CR);

  always_comb begin
    if (CMP_W'(value) > CMP_W'(VALUE_MAX)) begin
      result.angle_value = VALUE_MAX;
    end else begin
      result.angle_value = ANGLE_W'(value);
    end
    result.malformed = error_seen;
  end

  always_comb begin
    in_frame_next       = in_frame;
    frame_position_next = frame_position;
    value_next          = value;
    frac_count_next     = frac_count;
    point_seen_next     = point_seen;
    error_seen_next     = error_seen;
    if (rx_byte == CH_LF || rx_byte == CH_CR) begin
      in_frame_next       = (rx_byte == CH_LF);
      frame_position_next = '0;
      value_next          = '0;
      frac_count_next     = '0;
      point_seen_next     = 1'b0;
      error_seen_next     = 1'b0;
    end else if (in_frame && !error_seen) begin
      if (frame_position >= P_W'(FRAME_LENGTH - 1)) begin
        error_seen_next = 1'b1;
      end else if (pos_ext < hdr_ext) begin
        frame_position_next = frame_position + P_W'(1);
      end else if (pos_ext >= hdr_ext + (P_W+1)'(PAYLOAD_MAX)) begin
        error_seen_next = 1'b1;
      end else begin
        frame_position_next = frame_position + P_W'(1);
        if (rx_byte == CH_POINT) begin
          if (point_seen) begin
            error_seen_next = 1'b1;
          end else begin
            point_seen_next = 1'b1;
          end
        end else if (is_digit) begin
          if (!point_seen) begin
            value_next = (value << 3) + (value << 1) + VAL_W'(INT_SCALE * VAL_W'(digit));
          end else if (frac_count < CNT_W'(FRAC_DIGITS)) begin
            value_next      = value + VAL_W'(scale * VAL_W'(digit));
            frac_count_next = frac_count + CNT_W'(1);
          end
        end else begin
          error_seen_next = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame       <= 1'b0;
      frame_position <= '0;
      value          <= '0;
      frac_count     <= '0;
      point_seen     <= 1'b0;
      error_seen     <= 1'b0;
    end else if (step) begin
      in_frame       <= in_frame_next;
      frame_position <= frame_position_next;
      value          <= value_next;
      frac_count     <= frac_count_next;
      point_seen     <= point_seen_next;
      error_seen     <= error_seen_next;
    end
  end

endmodule

`default_nettype wire
